// ----- hdl/grid_cell_id_store_core_defines.svh -----
// Assertion macros for the cell store checker.
`ifndef GRID_CELL_ID_STORE_CORE_DEFINES_SVH
`define GRID_CELL_ID_STORE_CORE_DEFINES_SVH

// Same-cycle implication.
`define GCS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gcs assertion failed");

// Next-cycle implication.
`define GCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gcs assertion failed");

`endif

// ----- hdl/gcs_pkg.sv -----
package gcs_pkg;

	localparam int MAX_DIM   = 16;
	localparam int CELL_CAP  = 16;
	localparam int ID_BITS   = 32;

	localparam int NUM_CELLS = MAX_DIM * MAX_DIM * MAX_DIM;
	localparam int CELL_W    = $clog2(NUM_CELLS);
	localparam int SLOT_W    = $clog2(CELL_CAP);
	localparam int SLOTS     = NUM_CELLS * CELL_CAP;
	localparam int ADDR_W    = $clog2(SLOTS);

	// field widths fixed by the interface
	localparam int DIM_W   = 5;
	localparam int CMD_W   = 2;
	localparam int COORD_W = 4;
	localparam int SLOTF_W = 4;
	localparam int IDF_W   = 32;
	localparam int CNT_W   = 5;
	localparam int STAT_W  = 2;
	localparam int CFG_IDX_W = 2;

	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
	localparam logic [STAT_W-1:0] ST_OOR  = 2'd1;
	localparam logic [STAT_W-1:0] ST_SLOT = 2'd2;
	localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_DIM_I = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_J = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DIM_K = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [COORD_W-1:0] cell_i;
		logic [COORD_W-1:0] cell_j;
		logic [COORD_W-1:0] cell_k;
		logic [SLOTF_W-1:0] slot;
		logic [IDF_W-1:0]   new_id;
	} in_item_t;

	typedef struct packed {
		logic [IDF_W-1:0]  id_out;
		logic [CNT_W-1:0]  count;
		logic [STAT_W-1:0] status;
	} out_item_t;

	typedef struct packed {
		logic              capture;
		logic              cnt_rd;
		logic              commit;
		logic              slot_rd;
		logic              load_slot;
		logic              clr_en;
		logic [CELL_W-1:0] clr_addr;
	} dp_cmd_t;

	typedef struct packed {
		logic read_ok;
	} dp_stat_t;

endpackage

// ----- hdl/gcs_datapath.sv -----
module gcs_datapath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gcs_pkg::in_item_t          in_item,
	input  logic                       cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcs_pkg::DIM_W-1:0]  cfg_data,
	input  gcs_pkg::dp_cmd_t           cmd,
	output gcs_pkg::dp_stat_t          stat,
	output gcs_pkg::out_item_t         out_item
);

	localparam int CELL_W = gcs_pkg::CELL_W;
	localparam int CNT_W  = gcs_pkg::CNT_W;

	logic [gcs_pkg::DIM_W-1:0] dim_i_q, dim_j_q, dim_k_q;
	logic [gcs_pkg::DIM_W-1:0] di, dj, dk;

	gcs_pkg::in_item_t  req_q;
	logic [CELL_W-1:0]  p1_q;
	logic               oor_q;
	logic [CELL_W-1:0]  lin_q;
	logic [CELL_W-1:0]  lin_next;
	logic [CNT_W-1:0]   cnt_q;
	logic [gcs_pkg::ID_BITS-1:0] slot_rd_q;
	gcs_pkg::out_item_t res_q;

	logic [CNT_W-1:0]          res_cnt;
	logic [gcs_pkg::STAT_W-1:0] res_st;
	logic                      app_ok;
	logic                      clr_cell;
	logic                      read_ok;

	logic [CNT_W-1:0]          cnt_mem  [gcs_pkg::NUM_CELLS];
	logic [gcs_pkg::ID_BITS-1:0] slot_mem [gcs_pkg::SLOTS];

	localparam logic [gcs_pkg::DIM_W-1:0] DMAX = gcs_pkg::DIM_W'(gcs_pkg::MAX_DIM);

	assign di = (dim_i_q > DMAX) ? DMAX : dim_i_q;
	assign dj = (dim_j_q > DMAX) ? DMAX : dim_j_q;
	assign dk = (dim_k_q > DMAX) ? DMAX : dim_k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_i_q <= gcs_pkg::DIM_W'(16);
			dim_j_q <= gcs_pkg::DIM_W'(16);
			dim_k_q <= gcs_pkg::DIM_W'(16);
		end else if (cfg_we) begin
			unique case (cfg_index)
				gcs_pkg::REG_DIM_I: dim_i_q <= cfg_data;
				gcs_pkg::REG_DIM_J: dim_j_q <= cfg_data;
				gcs_pkg::REG_DIM_K: dim_k_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// linear index: (i*dj + j)*dk + k, one multiply per cycle
	assign lin_next = CELL_W'(p1_q * CELL_W'(dk) + CELL_W'(req_q.cell_k));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= in_item;
			p1_q  <= CELL_W'(CELL_W'(in_item.cell_i) * CELL_W'(dj) + CELL_W'(in_item.cell_j));
			oor_q <= ({1'b0, in_item.cell_i} >= di) || ({1'b0, in_item.cell_j} >= dj) ||
			         ({1'b0, in_item.cell_k} >= dk);
		end
		if (cmd.cnt_rd) begin
			lin_q <= lin_next;
			cnt_q <= cnt_mem[lin_next];
		end
	end

	always_comb begin
		res_cnt  = cnt_q;
		res_st   = gcs_pkg::ST_OK;
		app_ok   = 1'b0;
		clr_cell = 1'b0;
		read_ok  = 1'b0;
		if (oor_q) begin
			res_cnt = '0;
			res_st  = gcs_pkg::ST_OOR;
		end else begin
			unique case (req_q.command)
				gcs_pkg::CMD_APPEND: begin
					if (cnt_q >= CNT_W'(gcs_pkg::CELL_CAP)) begin
						res_st = gcs_pkg::ST_FULL;
					end else begin
						app_ok  = 1'b1;
						res_cnt = cnt_q + CNT_W'(1);
					end
				end
				gcs_pkg::CMD_READ: begin
					if (CNT_W'(req_q.slot) >= cnt_q) begin
						res_st = gcs_pkg::ST_SLOT;
					end else begin
						read_ok = 1'b1;
					end
				end
				gcs_pkg::CMD_CLEAR: begin
					clr_cell = 1'b1;
					res_cnt  = '0;
				end
				default: ;
			endcase
		end
	end

	assign stat.read_ok = read_ok;

	always_ff @(posedge clk) begin
		if (cmd.clr_en) begin
			cnt_mem[cmd.clr_addr] <= '0;
		end else if (cmd.commit && (app_ok || clr_cell)) begin
			cnt_mem[lin_q] <= res_cnt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && app_ok) begin
			slot_mem[{lin_q, cnt_q[gcs_pkg::SLOT_W-1:0]}] <= gcs_pkg::ID_BITS'(req_q.new_id);
		end
		if (cmd.slot_rd) begin
			slot_rd_q <= slot_mem[{lin_q, req_q.slot[gcs_pkg::SLOT_W-1:0]}];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			res_q.id_out <= '0;
			res_q.count  <= res_cnt;
			res_q.status <= res_st;
		end else if (cmd.load_slot) begin
			res_q.id_out <= gcs_pkg::IDF_W'(slot_rd_q);
			res_q.count  <= res_cnt;
			res_q.status <= res_st;
		end
	end

	assign out_item = res_q;

endmodule

// ----- hdl/gcs_ctrl.sv -----
module gcs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	input  gcs_pkg::dp_stat_t stat,
	output gcs_pkg::dp_cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LIN,
		S_EXEC,
		S_SLOT
	} state_t;

	state_t                     state_q;
	logic [gcs_pkg::CELL_W-1:0] clr_q;
	logic                       out_valid_q;
	logic                       out_free;
	logic                       load;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.clr_addr  = clr_q;
		cmd.clr_en    = (state_q == S_CLEAR);
		cmd.capture   = (state_q == S_IDLE) && in_valid;
		cmd.cnt_rd    = (state_q == S_LIN);
		cmd.slot_rd   = (state_q == S_EXEC) && stat.read_ok;
		cmd.commit    = (state_q == S_EXEC) && !stat.read_ok && out_free;
		cmd.load_slot = (state_q == S_SLOT) && out_free;
	end

	assign load = cmd.commit || cmd.load_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + gcs_pkg::CELL_W'(1);
					if (&clr_q) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_LIN;
					end
				end
				S_LIN: state_q <= S_EXEC;
				S_EXEC: begin
					if (stat.read_ok) begin
						state_q <= S_SLOT;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_SLOT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- hdl/grid_cell_id_store_core.sv -----
// Item flow: capture, count read in S_LIN, result registered in S_EXEC; a read that hits
// reads the slot memory in S_EXEC and registers the result in S_SLOT. No new item is taken
// until the result is registered (count read-modify-write and registered slot memory read);
// a waiting result holds S_EXEC or S_SLOT. Reset: asynchronous; afterwards all 4096 cell
// counts are cleared one cell per cycle with in_stall high. Dimensions reset to 16.
module grid_cell_id_store_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  gcs_pkg::in_item_t             in_item,
	output logic                          out_valid,
	input  logic                          out_stall,
	output gcs_pkg::out_item_t            out_item,
	input  logic                          cfg_we,
	input  logic [gcs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [gcs_pkg::DIM_W-1:0]     cfg_data
);

	gcs_pkg::dp_cmd_t  cmd;
	gcs_pkg::dp_stat_t stat;

	gcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	gcs_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_item   (in_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.out_item  (out_item)
	);

endmodule

// ----- hdl/gcs_checker.sv -----
`include "grid_cell_id_store_core_defines.svh"

module gcs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic               out_valid,
	input logic               out_stall,
	input gcs_pkg::out_item_t out_item
);

	`GCS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_item))
	`GCS_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
	`GCS_ASSERT_NOW(a_oor_zero, out_valid && (out_item.status == gcs_pkg::ST_OOR), (out_item.count == '0) && (out_item.id_out == '0))
	`GCS_ASSERT_NOW(a_err_no_id, out_valid && ((out_item.status == gcs_pkg::ST_SLOT) || (out_item.status == gcs_pkg::ST_FULL)), out_item.id_out == '0)
	`GCS_ASSERT_NOW(a_full_count, out_valid && (out_item.status == gcs_pkg::ST_FULL), out_item.count == gcs_pkg::CNT_W'(gcs_pkg::CELL_CAP))

endmodule

bind grid_cell_id_store_core gcs_checker u_gcs_checker (.*);
